FILE: rtl/core/dlf_pkg.sv
// Package for the dense layer forward core: data widths, request and
// register codes, sequencer states and the sigmoid knot table.
// No dependencies.
`default_nettype none

package dlf_pkg;

	localparam int DATA_W     = 16;
	localparam int FRAC_W     = 12;
	localparam int ACC_W      = 40;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int SUM_W      = ACC_W + 1;
	localparam int ROW_W      = 4;
	localparam int COL_W      = 6;
	localparam int ROWS       = 16;
	localparam int COLS       = 64;
	localparam int IN_CNT_W   = 7;
	localparam int OUT_CNT_W  = 5;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 7;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 24;
	localparam int KNOT_W     = 13;
	localparam int KNOT_IDX_W = 5;
	localparam int SEG_W      = 11;
	localparam int MAG_W      = 15;

	localparam logic [REQ_W-1:0] REQ_WEIGHT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_BIAS   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ELEM   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 2'd2;

	localparam logic ACT_TANH    = 1'b0;
	localparam logic ACT_SIGMOID = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_SUM,
		ST_ACT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic issue;
		logic sum_en;
		logic act_en;
		logic load;
	} ctl_t;

	localparam logic [KNOT_W-1:0] SIG_KNOTS [0:16] = '{
		13'd2048, 13'd2550, 13'd2994, 13'd3349, 13'd3608, 13'd3785,
		13'd3902, 13'd3976, 13'd4022, 13'd4051, 13'd4069, 13'd4079,
		13'd4086, 13'd4090, 13'd4092, 13'd4094, 13'd4095
	};

endpackage

`default_nettype wire

FILE: rtl/core/dlf_mul.sv
// Shared signed multiplier with a registered product for the dense layer core.
// Depends on dlf_pkg.
`default_nettype none

module dlf_mul
	import dlf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [DATA_W-1:0] a,
	input  wire logic signed [DATA_W-1:0] b,
	output logic signed [PROD_W-1:0]      p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/dense_layer_forward_core.sv
// Fully connected layer y = act(W x + b) with a tanh or sigmoid activation.
// Weight or bias transfer: accepted while idle; the input is ready again in the next cycle.
// Input element: the input is held off while one shared multiplier walks the rows,
// one weight memory read and one product per cycle, until the pipeline drains.
// Closing element: each row then takes ST_SUM, ST_ACT and ST_OUT, and waits in ST_OUT on stalls.
// Reset (arst_n low): sequencer idle, accumulators zero, registers to defaults, no memory reset.
`default_nettype none

module dense_layer_forward_core
	import dlf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [CFG_IDX_W-1:0]   wr_index,
	input  wire logic [CFG_W-1:0]       wr_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// row_index [3:0], col_index [9:4], data_value [25:10], zero [31:26]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type [1:0]
	input  wire logic [REQ_W-1:0]       s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// neuron_index [3:0], activated_value [19:4], zero [23:20]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// last_of_vector
	output logic                        m_axis_tlast
);

	state_t state_q, state_d;
	ctl_t   ctl;

	logic                  act_mode_q;
	logic [IN_CNT_W-1:0]   in_cnt_q;
	logic [OUT_CNT_W-1:0]  out_cnt_q;
	logic [IN_CNT_W-1:0]   n_in;
	logic [OUT_CNT_W-1:0]  n_out;

	logic                     in_fire;
	logic [ROW_W-1:0]         in_row;
	logic [COL_W-1:0]         in_col;
	logic signed [DATA_W-1:0] in_val;
	logic                     elem_go;

	logic signed [DATA_W-1:0] x_q;
	logic [COL_W-1:0]         col_q;
	logic                     last_q;
	logic [OUT_CNT_W-1:0]     issue_q;
	logic                     issue_more;
	logic                     mac_done;

	logic [DATA_W-1:0]        wmem [0:ROWS*COLS-1];
	logic [DATA_W-1:0]        bmem [0:ROWS-1];
	logic                     rd_v_s1;
	logic [ROW_W-1:0]         rd_row_s1;
	logic signed [DATA_W-1:0] w_s1;
	logic                     mul_v_s2;
	logic [ROW_W-1:0]         mul_row_s2;

	logic signed [DATA_W-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic                     mul_en;
	logic signed [PROD_W-1:0] prod;

	logic [ACC_W-1:0]         acc_q [0:ROWS-1];
	logic [ROW_W-1:0]         row_q;
	logic                     last_row;
	logic signed [SUM_W-1:0]  sum_q;

	logic [SUM_W-FRAC_W-1:0]  q_full;
	logic                     q_in_rng;
	logic [DATA_W-1:0]        q_sat;
	logic [DATA_W-1:0]        q_neg;
	logic                     q_is_neg;
	logic [MAG_W-1:0]         mag;
	logic [MAG_W-1:0]         mag2;
	logic [MAG_W-1:0]         mag_sel;
	logic [KNOT_IDX_W-1:0]    k_idx;
	logic [SEG_W-1:0]         seg_f;
	logic [KNOT_W-1:0]        k0;
	logic [KNOT_W-1:0]        k1;
	logic [DATA_W-1:0]        k_diff;
	logic [KNOT_W-1:0]        knot_q;
	logic                     neg_q;

	logic [KNOT_W-1:0]        p_val;
	logic [DATA_W-1:0]        sig_y;
	logic [DATA_W-1:0]        tanh_t;
	logic [DATA_W-1:0]        tanh_y;
	logic [DATA_W-1:0]        y_val;

	logic                     m_valid_q;
	logic [ROW_W-1:0]         m_idx_q;
	logic [DATA_W-1:0]        m_val_q;
	logic                     m_last_q;

	// effective counts
	always_comb begin
		if (in_cnt_q == '0) begin
			n_in = IN_CNT_W'(1);
		end else if (in_cnt_q > IN_CNT_W'(COLS)) begin
			n_in = IN_CNT_W'(COLS);
		end else begin
			n_in = in_cnt_q;
		end
		if (out_cnt_q == '0) begin
			n_out = OUT_CNT_W'(1);
		end else if (out_cnt_q > OUT_CNT_W'(ROWS)) begin
			n_out = OUT_CNT_W'(ROWS);
		end else begin
			n_out = out_cnt_q;
		end
	end

	assign in_row  = s_axis_tdata[ROW_W-1:0];
	assign in_col  = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
	assign in_val  = s_axis_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign elem_go = in_fire && (s_axis_tuser == REQ_ELEM)
		&& ({1'b0, in_col} < n_in);

	assign issue_more = issue_q < n_out;
	assign mac_done   = !issue_more && !rd_v_s1 && !mul_v_s2;
	assign last_row   = {1'b0, row_q} == (n_out - OUT_CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (elem_go) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (mac_done) state_d = last_q ? ST_SUM : ST_IDLE;
			end
			ST_SUM:  state_d = ST_ACT;
			ST_ACT:  state_d = ST_OUT;
			ST_OUT: begin
				if (ctl.load) state_d = last_row ? ST_IDLE : ST_SUM;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: ctl.in_ready = 1'b1;
			ST_MAC:  ctl.issue    = issue_more;
			ST_SUM:  ctl.sum_en   = 1'b1;
			ST_ACT:  ctl.act_en   = 1'b1;
			ST_OUT:  ctl.load     = !m_valid_q || m_axis_tready;
			default: ctl = '0;
		endcase
	end

	assign s_axis_tready = ctl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= ACT_SIGMOID;
			in_cnt_q   <= IN_CNT_W'(COLS);
			out_cnt_q  <= OUT_CNT_W'(ROWS);
		end else if (wr_en) begin
			case (wr_index)
				REG_ACT_MODE:  act_mode_q <= wr_data[0];
				REG_IN_COUNT:  in_cnt_q   <= wr_data[IN_CNT_W-1:0];
				REG_OUT_COUNT: out_cnt_q  <= wr_data[OUT_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (elem_go) begin
			x_q    <= in_val;
			col_q  <= in_col;
			last_q <= {1'b0, in_col} == (n_in - IN_CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (s_axis_tuser == REQ_WEIGHT)) begin
			wmem[{in_row, in_col}] <= in_val;
		end
		w_s1 <= wmem[{issue_q[ROW_W-1:0], col_q}];
	end

	always_ff @(posedge clk) begin
		if (in_fire && (s_axis_tuser == REQ_BIAS)) begin
			bmem[in_row] <= in_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			rd_v_s1    <= 1'b0;
			rd_row_s1  <= '0;
			mul_v_s2   <= 1'b0;
			mul_row_s2 <= '0;
		end else begin
			if (elem_go) begin
				issue_q <= '0;
			end else if (ctl.issue) begin
				issue_q <= issue_q + OUT_CNT_W'(1);
			end
			rd_v_s1    <= ctl.issue;
			rd_row_s1  <= issue_q[ROW_W-1:0];
			mul_v_s2   <= rd_v_s1;
			mul_row_s2 <= rd_row_s1;
		end
	end

	// one product per cycle: weight times element, or knot slope times offset
	assign mul_en = rd_v_s1 || ctl.act_en;
	assign mul_a  = ctl.act_en ? k_diff : w_s1;
	assign mul_b  = ctl.act_en ? {{(DATA_W-SEG_W){1'b0}}, seg_f} : x_q;

	dlf_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (ctl.load && last_row) begin
			for (int i = 0; i < ROWS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (mul_v_s2) begin
			acc_q[mul_row_s2] <= acc_q[mul_row_s2]
				+ {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (state_q == ST_MAC && mac_done) begin
			row_q <= '0;
		end else if (ctl.load) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

	// accumulator plus bias plus half an LSB
	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			sum_q <= $signed({acc_q[row_q][ACC_W-1], acc_q[row_q]})
				+ $signed({{(SUM_W-DATA_W-FRAC_W){bmem[row_q][DATA_W-1]}},
					bmem[row_q], {FRAC_W{1'b0}}})
				+ $signed(SUM_W'(1) << (FRAC_W - 1));
		end
	end

	always_comb begin
		q_full   = sum_q[SUM_W-1:FRAC_W];
		q_in_rng = (&q_full[SUM_W-FRAC_W-1:DATA_W-1])
			|| !(|q_full[SUM_W-FRAC_W-1:DATA_W-1]);
		if (q_in_rng) begin
			q_sat = q_full[DATA_W-1:0];
		end else if (q_full[SUM_W-FRAC_W-1]) begin
			q_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			q_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
		q_is_neg = q_sat[DATA_W-1];
		q_neg    = -q_sat;
		if (!q_is_neg) begin
			mag = q_sat[MAG_W-1:0];
		end else if (q_sat == {1'b1, {(DATA_W-1){1'b0}}}) begin
			mag = {MAG_W{1'b1}};
		end else begin
			mag = q_neg[MAG_W-1:0];
		end
		mag2    = mag[MAG_W-1] ? {MAG_W{1'b1}} : {mag[MAG_W-2:0], 1'b0};
		mag_sel = (act_mode_q == ACT_SIGMOID) ? mag : mag2;
		k_idx   = {1'b0, mag_sel[MAG_W-1:SEG_W]};
		seg_f   = mag_sel[SEG_W-1:0];
		k0      = SIG_KNOTS[k_idx];
		k1      = SIG_KNOTS[k_idx + KNOT_IDX_W'(1)];
		k_diff  = DATA_W'(k1) - DATA_W'(k0);
	end

	always_ff @(posedge clk) begin
		if (ctl.act_en) begin
			knot_q <= k0;
			neg_q  <= q_is_neg;
		end
	end

	always_comb begin
		p_val  = knot_q + prod[KNOT_W+SEG_W-1:SEG_W];
		sig_y  = neg_q ? (DATA_W'(1 << FRAC_W) - DATA_W'(p_val)) : DATA_W'(p_val);
		tanh_t = DATA_W'({p_val, 1'b0}) - DATA_W'(1 << FRAC_W);
		tanh_y = neg_q ? -tanh_t : tanh_t;
		y_val  = (act_mode_q == ACT_SIGMOID) ? sig_y : tanh_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			m_idx_q  <= row_q;
			m_val_q  <= y_val;
			m_last_q <= last_row;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-ROW_W-DATA_W){1'b0}}, m_val_q, m_idx_q};
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/dlf_checker.sv
// Port-level checks for the dense layer forward core, bound to the top level.
// Depends on dlf_pkg and dense_layer_forward_core.
`default_nettype none

module dlf_checker
	import dlf_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [REQ_W-1:0]       s_axis_tuser,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tlast
);

	// store writes and ignored requests never stall the input
	a_store_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_ELEM)
		|=> s_axis_tready)
		else $error("input stalled after a store transfer");

	// a result is produced only while the input side is held off
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared while input side was ready");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output transfer changed");

endmodule

bind dense_layer_forward_core dlf_checker u_dlf_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for dense_layer_forward_core: drives weight, bias and element transfers
// on the input stream and compares every neuron output against a local fixed-point predictor.
// Depends on dlf_pkg for widths, request codes and register indexes.

module testbench;
	import dlf_pkg::*;

	localparam logic [REQ_W-1:0]     REQ_NONE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_PAD     = 3 * ROWS + 32;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 150;

	typedef struct {
		logic [ROW_W-1:0]         neuron;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} neuron_result_t;

	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_MOSTLY,
		RX_PATTERN
	} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   wr_index = '0;
	logic [CFG_W-1:0]       wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [REQ_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	logic signed [DATA_W-1:0] weight_mem [0:ROWS*COLS-1];
	bit                       weight_set [0:ROWS*COLS-1];
	logic signed [DATA_W-1:0] bias_mem [0:ROWS-1];
	bit                       bias_set [0:ROWS-1];
	logic [ACC_W-1:0]         row_acc [0:ROWS-1];
	logic                     cfg_mode = ACT_SIGMOID;
	logic [IN_CNT_W-1:0]      cfg_in = 7'd64;
	logic [OUT_CNT_W-1:0]     cfg_out = 5'd16;

	neuron_result_t expected_neurons [$];
	neuron_result_t head_neuron;
	int errors = 0;
	int cycle_count = 0;
	int results_seen = 0;
	int useful_items = 0;
	bit sender_gaps = 1'b1;
	int burst_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int rx_hold = 0;
	int rx_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	logic [7:0] rx_pattern = 8'hFF;

	dense_layer_forward_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int knot(int i);
		case (i)
			0: return 2048;
			1: return 2550;
			2: return 2994;
			3: return 3349;
			4: return 3608;
			5: return 3785;
			6: return 3902;
			7: return 3976;
			8: return 4022;
			9: return 4051;
			10: return 4069;
			11: return 4079;
			12: return 4086;
			13: return 4090;
			14: return 4092;
			15: return 4094;
			default: return 4095;
		endcase
	endfunction

	function automatic int sigmoid_pos(int a);
		int i, f;
		i = (a >> 11) & 15;
		f = a & 2047;
		return knot(i) + (((knot(i + 1) - knot(i)) * f) >>> 11);
	endfunction

	function automatic int activate(int q);
		int a, a2, t;
		a = (q < 0) ? -q : q;
		if (a > 32767)
			a = 32767;
		if (cfg_mode == ACT_SIGMOID)
			return (q < 0) ? 4096 - sigmoid_pos(a) : sigmoid_pos(a);
		a2 = (a > 16383) ? 32767 : 2 * a;
		t = 2 * sigmoid_pos(a2) - 4096;
		return (q < 0) ? -t : t;
	endfunction

	function automatic int active_inputs();
		if (cfg_in == 0)
			return 1;
		return (cfg_in > COLS) ? COLS : int'(cfg_in);
	endfunction

	function automatic int active_rows();
		if (cfg_out == 0)
			return 1;
		return (cfg_out > ROWS) ? ROWS : int'(cfg_out);
	endfunction

	function automatic void absorb_transfer(logic [REQ_W-1:0] req, logic [ROW_W-1:0] row,
			logic [COL_W-1:0] col, logic signed [DATA_W-1:0] data);
		int n_in, n_out;
		longint prod, sum;
		neuron_result_t res;
		n_in = active_inputs();
		n_out = active_rows();
		case (req)
			REQ_WEIGHT: begin
				weight_mem[int'({row, col})] = data;
				weight_set[int'({row, col})] = 1'b1;
			end
			REQ_BIAS: begin
				bias_mem[row] = data;
				bias_set[row] = 1'b1;
			end
			REQ_ELEM: begin
				if (col < n_in) begin
					for (int r = 0; r < n_out; r++) begin
						prod = longint'(weight_mem[r * COLS + col]) * longint'(data);
						row_acc[r] = row_acc[r] + prod[ACC_W-1:0];
					end
					if (col == n_in - 1) begin
						for (int r = 0; r < n_out; r++) begin
							sum = longint'($signed(row_acc[r])) + longint'(bias_mem[r]) * 4096;
							sum = (sum + 2048) >>> FRAC_W;
							if (sum > 32767)
								sum = 32767;
							else if (sum < -32768)
								sum = -32768;
							res.neuron = ROW_W'(r);
							res.value = DATA_W'(activate(int'(sum)));
							res.last = (r == n_out - 1);
							expected_neurons.insert(expected_neurons.size(), res);
						end
						foreach (row_acc[r])
							row_acc[r] = '0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_neurons.size() == 0) begin
				report_mismatch("unexpected transfer, tdata", m_axis_tdata, 0);
			end else begin
				head_neuron = expected_neurons.pop_front();
				if (m_axis_tdata[ROW_W-1:0] !== head_neuron.neuron)
					report_mismatch("neuron_index", m_axis_tdata[ROW_W-1:0], head_neuron.neuron);
				if ($signed(m_axis_tdata[ROW_W +: DATA_W]) !== head_neuron.value)
					report_mismatch("activated_value", $signed(m_axis_tdata[ROW_W +: DATA_W]),
						head_neuron.value);
				if (m_axis_tlast !== head_neuron.last)
					report_mismatch("last_of_vector", m_axis_tlast, head_neuron.last);
			end
		end
	end

	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			rx_hold = HOLD_CYCLES;
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(32, 256);
			rx_pattern = 8'($urandom);
		end
		rx_left--;
		rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_HALF: m_axis_tready <= ($urandom_range(0, 1) == 1);
				RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
				default: m_axis_tready <= rx_pattern[0];
			endcase
		end
	end

	task automatic send_item(input logic [REQ_W-1:0] req, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [DATA_W-1:0] data);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({data, col, row});
		s_axis_tuser <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (req != REQ_NONE && !(req == REQ_ELEM && col >= active_inputs()))
			useful_items++;
		absorb_transfer(req, row, col, data);
		if (sender_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_neurons.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_ACT_MODE: cfg_mode = value[0];
			REG_IN_COUNT: cfg_in = value;
			REG_OUT_COUNT: cfg_out = value[OUT_CNT_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					3: return 16'h0000;
					default: return 16'h0001;
				endcase
			end
			1, 2: return DATA_W'($urandom_range(0, 128)) - 16'd64;
			3, 4: return DATA_W'($urandom_range(0, 8192)) - 16'd4096;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// fill in any weight or bias the element would read before sending it
	task automatic send_elem(input logic [COL_W-1:0] col, input logic [DATA_W-1:0] data);
		int n_in, n_out;
		n_in = active_inputs();
		n_out = active_rows();
		if (col < n_in) begin
			for (int r = 0; r < n_out; r++)
				if (!weight_set[r * COLS + col])
					send_item(REQ_WEIGHT, ROW_W'(r), col, random_value());
			if (col == n_in - 1)
				for (int r = 0; r < n_out; r++)
					if (!bias_set[r])
						send_item(REQ_BIAS, ROW_W'(r), COL_W'($urandom), random_value());
		end
		send_item(REQ_ELEM, ROW_W'($urandom), col, data);
	endtask

	task automatic test_reset_defaults();
		send_elem(COL_W'(COLS - 1), 16'h1000);
		wait_idle();
	endtask

	task automatic test_field_extremes();
		logic [4*DATA_W-1:0] col0_w, col1_w, bias_w;
		col0_w = {16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF};
		col1_w = {16'h0001, 16'h0000, 16'h8000, 16'h8000};
		bias_w = {16'h0800, 16'h0000, 16'h8000, 16'h7FFF};
		write_reg(REG_ACT_MODE, CFG_W'(ACT_TANH));
		write_reg(REG_IN_COUNT, CFG_W'(2));
		write_reg(REG_OUT_COUNT, CFG_W'(4));
		for (int r = 0; r < 4; r++) begin
			send_item(REQ_WEIGHT, ROW_W'(r), 6'd0, col0_w[r*DATA_W +: DATA_W]);
			send_item(REQ_WEIGHT, ROW_W'(r), 6'd1, col1_w[r*DATA_W +: DATA_W]);
			send_item(REQ_BIAS, ROW_W'(r), 6'h3F, bias_w[r*DATA_W +: DATA_W]);
		end
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1) begin
				wait_idle();
				write_reg(REG_ACT_MODE, CFG_W'(ACT_SIGMOID));
			end
			send_elem(6'd0, 16'h8000);
			send_elem(6'd1, 16'h7FFF);
		end
		wait_idle();
	endtask

	task automatic test_special_cases();
		// sums of +4.5 and -4.5 lsb: round half up, visible through tanh
		write_reg(REG_ACT_MODE, CFG_W'(ACT_TANH));
		write_reg(REG_IN_COUNT, CFG_W'(1));
		write_reg(REG_OUT_COUNT, CFG_W'(2));
		send_item(REQ_WEIGHT, 4'd0, 6'd0, 16'h0009);
		send_item(REQ_WEIGHT, 4'd1, 6'd0, 16'hFFF7);
		send_item(REQ_BIAS, 4'd0, 6'd0, 16'h0000);
		send_item(REQ_BIAS, 4'd1, 6'd0, 16'h0000);
		send_item(REQ_NONE, 4'hF, 6'h00, 16'h7FFF);
		send_elem(6'd5, 16'h4000);
		send_elem(6'd0, 16'h0800);
		wait_idle();
		write_reg(REG_UNUSED, 7'h7F);
		write_reg(REG_IN_COUNT, CFG_W'(0));
		write_reg(REG_OUT_COUNT, CFG_W'(0));
		send_elem(6'd0, 16'hF000);
		wait_idle();
		write_reg(REG_IN_COUNT, 7'h7F);
		write_reg(REG_OUT_COUNT, 7'h7F);
		write_reg(REG_ACT_MODE, 7'h7E);
		send_elem(COL_W'(COLS - 1), 16'hC000);
		wait_idle();
	endtask

	task automatic test_backpressure();
		write_reg(REG_ACT_MODE, CFG_W'($urandom));
		write_reg(REG_IN_COUNT, CFG_W'(1));
		write_reg(REG_OUT_COUNT, CFG_W'(ROWS));
		sender_gaps = 1'b0;
		hold_requests++;
		repeat (4)
			send_elem(6'd0, random_value());
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int start_items, start_results, vectors_left, n_in, kind, val, j, tmp;
		int cols [0:COLS-1];
		start_items = useful_items;
		start_results = results_seen;
		vectors_left = 0;
		while (useful_items - start_items < RANDOM_ITEMS || results_seen - start_results < 48) begin
			if (vectors_left == 0) begin
				wait_idle();
				write_reg(REG_ACT_MODE, CFG_W'($urandom));
				case ($urandom_range(0, 11))
					0: val = 0;
					1: val = COLS;
					2: val = $urandom_range(COLS + 1, 127);
					default: val = $urandom_range(1, 6);
				endcase
				write_reg(REG_IN_COUNT, CFG_W'(val));
				if (active_inputs() > ROWS) begin
					val = $urandom_range(1, 3);
				end else begin
					case ($urandom_range(0, 7))
						0: val = 0;
						1: val = ROWS;
						2: val = $urandom_range(ROWS + 1, 31);
						default: val = $urandom_range(1, ROWS);
					endcase
				end
				write_reg(REG_OUT_COUNT, CFG_W'(val + 32 * $urandom_range(0, 3)));
				if ($urandom_range(0, 5) == 0)
					write_reg(REG_UNUSED, CFG_W'($urandom));
				vectors_left = $urandom_range(2, 6);
			end
			sender_gaps = ($urandom_range(0, 3) != 0);
			n_in = active_inputs();
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				for (int c = 0; c < n_in - 1; c++)
					cols[c] = c;
				if (kind < 3) begin
					for (int c = n_in - 2; c > 0; c--) begin
						j = $urandom_range(0, c);
						tmp = cols[c];
						cols[c] = cols[j];
						cols[j] = tmp;
					end
				end
				for (int c = 0; c < n_in - 1; c++) begin
					// keep long vectors sparse
					if (n_in > ROWS && $urandom_range(0, 7) != 0)
						continue;
					if ($urandom_range(0, 7) == 0)
						send_item(REQ_WEIGHT, ROW_W'($urandom), COL_W'($urandom), random_value());
					send_elem(COL_W'(cols[c]), random_value());
				end
				send_elem(COL_W'(n_in - 1), random_value());
			end else begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0: send_item(REQ_WEIGHT, ROW_W'($urandom), COL_W'($urandom), random_value());
						1: send_item(REQ_BIAS, ROW_W'($urandom), COL_W'($urandom), random_value());
						2: send_elem(COL_W'($urandom), random_value());
						default: send_item(REQ_NONE, ROW_W'($urandom), COL_W'($urandom),
							DATA_W'($urandom));
					endcase
				end
			end
			vectors_left--;
		end
		wait_idle();
	endtask

	initial begin
		foreach (row_acc[r])
			row_acc[r] = '0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_field_extremes();
		test_special_cases();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/dlf_pkg.sv
rtl/core/dlf_mul.sv
rtl/core/dense_layer_forward_core.sv
rtl/core/dlf_checker.sv
tb/testbench.sv
